// File: design/ppre_pkg.sv
// Package: shared constants and types for the packed pixel to RGBA expander.
package ppre_pkg;

    localparam int unsigned PALETTE_DEPTH = 256;
    localparam int unsigned PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int unsigned PIX_W         = 32;
    localparam int unsigned IDX_W         = 8;

    localparam logic CMD_CONVERT = 1'b0;
    localparam logic CMD_WRITE   = 1'b1;

    typedef enum logic [3:0] {
        FMT_PAL1     = 4'd0,
        FMT_PAL2     = 4'd1,
        FMT_PAL4     = 4'd2,
        FMT_PAL8     = 4'd3,
        FMT_RGBA2321 = 4'd4,
        FMT_RGB565   = 4'd5,
        FMT_RGBA5551 = 4'd6,
        FMT_RGBI5551 = 4'd7,
        FMT_RGB666   = 4'd8,
        FMT_RGBA6651 = 4'd9,
        FMT_RGBA6661 = 4'd10,
        FMT_RGB888   = 4'd11,
        FMT_RGBA8871 = 4'd12,
        FMT_RGBA8881 = 4'd13,
        FMT_RGBA8884 = 4'd14
    } fmt_t;

endpackage

// File: design/packed_pixel_to_rgba_expander_core.sv
// Top level: packed pixel to RGBA8888 expander with palette RAM.
// An accepted item is held in the stage-1 registers (with the palette RAM read register), then in the output register.
// Throughput: one item per cycle while m_axis_tready is high; the palette RAM has one read and one write port.
// Write-palette items give no result.
// Reset clears pipeline valids and sets pixel_format to RGB-565 (code 5).
// Palette contents are undefined after reset until written; there is no clearing pass.
module packed_pixel_to_rgba_expander_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_format_we,
    input  logic [3:0]  pixel_format_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // color[31:0], palette_index[39:32], palette_value[71:40]
    input  logic [0:0]  s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // rgba[31:0]
);

    localparam int unsigned AW = ppre_pkg::PAL_AW;

    ppre_pkg::fmt_t pixel_format_reg;

    logic [31:0] in_color;
    logic [7:0]  in_idx;
    logic [31:0] in_value;
    logic        in_accept;
    logic        in_write;
    logic        is_pal;
    logic [7:0]  rd_idx;
    logic        rd_hit;
    logic        wr_hit;
    logic [31:0] direct;
    logic [31:0] ram_rdata;

    logic        s1_vld_reg, s1_vld_next;
    logic        s1_pal_reg;
    logic        s1_hit_reg;
    logic [31:0] s1_direct_reg;
    logic        out_vld_reg, out_vld_next;
    logic [31:0] out_data_reg;
    logic        advance;

    assign in_color = s_axis_tdata[31:0];
    assign in_idx   = s_axis_tdata[39:32];
    assign in_value = s_axis_tdata[71:40];
    assign in_write = (s_axis_tuser[0] == ppre_pkg::CMD_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= ppre_pkg::FMT_RGB565;
        end
        else if (pixel_format_we)
        begin
            pixel_format_reg <= ppre_pkg::fmt_t'(pixel_format_wdata);
        end
    end

    // stage 1 moves on when the output register is empty or being drained
    assign advance       = s1_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !s1_vld_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        is_pal = 1'b1;
        case (pixel_format_reg)
            ppre_pkg::FMT_PAL1: rd_idx = {7'd0, in_color[0]};
            ppre_pkg::FMT_PAL2: rd_idx = {6'd0, in_color[1:0]};
            ppre_pkg::FMT_PAL4: rd_idx = {4'd0, in_color[3:0]};
            ppre_pkg::FMT_PAL8: rd_idx = in_color[7:0];
            default:
            begin
                rd_idx = '0;
                is_pal = 1'b0;
            end
        endcase
    end

    assign rd_hit = ({1'b0, rd_idx} < 9'(ppre_pkg::PALETTE_DEPTH));
    assign wr_hit = ({1'b0, in_idx} < 9'(ppre_pkg::PALETTE_DEPTH));

    ppre_direct_expand u_expand (
        .fmt   (pixel_format_reg),
        .color (in_color),
        .rgba  (direct)
    );

    // write and read of one entry never share an edge: each item does one or the other
    ppre_palette_ram #(
        .DEPTH (ppre_pkg::PALETTE_DEPTH),
        .WIDTH (ppre_pkg::PIX_W)
    ) u_palette (
        .clk   (clk),
        .we    (in_accept && in_write && wr_hit),
        .waddr (in_idx[AW-1:0]),
        .wdata (in_value),
        .re    (in_accept && !in_write && is_pal),
        .raddr (rd_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (in_accept)
        begin
            s1_vld_next = !in_write;
        end
        else if (advance)
        begin
            s1_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pal_reg    <= is_pal;
            s1_hit_reg    <= rd_hit;
            s1_direct_reg <= direct;
        end
        if (advance)
        begin
            if (s1_pal_reg)
            begin
                out_data_reg <= s1_hit_reg ? ram_rdata : '0;
            end
            else
            begin
                out_data_reg <= s1_direct_reg;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: design/ppre_palette_ram.sv
// Palette storage: single write port, single registered read port.
module ppre_palette_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/ppre_direct_expand.sv
// Direct-format expansion of a packed color word to RGBA8888.
module ppre_direct_expand (
    input  ppre_pkg::fmt_t                 fmt,
    input  logic [ppre_pkg::PIX_W-1:0]     color,
    output logic [ppre_pkg::PIX_W-1:0]     rgba
);

    function automatic logic [31:0] spread(input logic b);
        return {24'h0, {8{b}}};
    endfunction

    logic [31:0] c;
    logic [31:0] r;
    logic [31:0] g;

    assign c = color;

    always_comb
    begin
        r = '0;
        g = '0;
        case (fmt)
            ppre_pkg::FMT_RGBA2321:
            begin
                r = (c & 32'h6000_0000) << 1;
                r = r | ((c & 32'h0300_0000) >> 10);
                r = r | (r >> 2);
                r = r | (r >> 4);
                g = c & 32'h0000_001C;
                g = g | (g << 3) | (g >> 3);
                r = r | (g << 16) | spread(c[31]);
            end
            ppre_pkg::FMT_RGB565:
            begin
                r = c & 32'hF800_0000;
                r = r | ((c & 32'h001F_0000) >> 5);
                r = r | (r >> 5);
                r = r & 32'hFF00_FFFF;
                r = r | ((c & 32'h07E0_0000) >> 3);
                r = r & 32'hFFFF_FF00;
                r = r | ((c & 32'h0600_0000) >> 9);
            end
            ppre_pkg::FMT_RGBA5551, ppre_pkg::FMT_RGBI5551:
            begin
                r = (c & 32'h7C00_0000) << 1;
                r = r | ((c & 32'h03E0_0000) >> 2);
                r = r | ((c & 32'h001F_0000) >> 5);
                r = r | ((r & 32'hE0E0_E000) >> 5);
                r = r | spread(c[31]);
            end
            ppre_pkg::FMT_RGB666, ppre_pkg::FMT_RGBA6661:
            begin
                r = (c & 32'h0003_F000) << 14;
                r = r | ((c & 32'h0000_0FC0) << 12);
                r = r | ((c & 32'h0000_003F) << 10);
                r = r | ((r & 32'hC0C0_C000) >> 6);
                if (fmt == ppre_pkg::FMT_RGBA6661)
                begin
                    r = r | spread(c[18]);
                end
            end
            ppre_pkg::FMT_RGBA6651:
            begin
                r = (c & 32'h0001_F800) << 15;
                r = r | ((c & 32'h0000_07E0) << 13);
                r = r | ((c & 32'h0000_001F) << 11);
                r = r | ((r & 32'hC0C0_0000) >> 6);
                r = r | ((r & 32'h0000_E000) >> 5);
                r = r | spread(c[17]);
            end
            ppre_pkg::FMT_RGB888:
            begin
                r = c << 8;
            end
            ppre_pkg::FMT_RGBA8871:
            begin
                r = (c << 9) | ((c & 32'h0000_0040) << 2) | spread(c[23]);
            end
            ppre_pkg::FMT_RGBA8881:
            begin
                r = (c << 8) | spread(c[24]);
            end
            ppre_pkg::FMT_RGBA8884:
            begin
                g = c & 32'h0F00_0000;
                r = (c << 8) | (g >> 24) | (g >> 20);
            end
            default:
            begin
                // palette formats are resolved by the caller; unused code gives zero
                r = '0;
            end
        endcase
        rgba = r;
    end

endmodule

// File: design/ppre_checker.sv
// Port-level checker for the expander core, bound to the top level.
module ppre_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic convert_xfer;

    assign convert_xfer = s_axis_tvalid && s_axis_tready &&
                          (s_axis_tuser[0] == ppre_pkg::CMD_CONVERT);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // input side can only stall when a result is waiting on the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    a_convert_result: assert property (@(posedge clk) disable iff (!rst_n)
        convert_xfer |=> ##1 m_axis_tvalid)
        else $error("convert transfer gave no result two cycles later");

endmodule

bind packed_pixel_to_rgba_expander_core ppre_checker u_ppre_checker (.*);

// File: tb/tb_packed_pixel_to_rgba_expander_core.sv
// Testbench for the expander core: directed and random streams checked against a predictor.
module tb_packed_pixel_to_rgba_expander_core;

    // code 15 has no layout behind it; the block answers zero
    localparam logic [3:0] FMT_UNUSED = 4'd15;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 80;

    logic        clk;
    logic        rst_n;
    logic        pixel_format_we;
    logic [3:0]  pixel_format_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // color[31:0], palette_index[39:32], palette_value[71:40]
    logic [0:0]  s_axis_tuser;   // command[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // rgba[31:0]

    logic [3:0]  fmt_now;
    logic [31:0] pal_shadow [ppre_pkg::PALETTE_DEPTH];
    bit          pal_written [ppre_pkg::PALETTE_DEPTH];
    logic [31:0] rgba_due [$];
    logic [31:0] rgba_want;
    int          mismatches;
    bit          tx_idle_en;
    bit          rx_idle_en;
    int          hold_requests;
    int          hold_served;

    packed_pixel_to_rgba_expander_core DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .pixel_format_we    (pixel_format_we),
        .pixel_format_wdata (pixel_format_wdata),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .s_axis_tuser       (s_axis_tuser),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] index_mask(logic [3:0] fmt);
        case (fmt)
            ppre_pkg::FMT_PAL1: return 8'h01;
            ppre_pkg::FMT_PAL2: return 8'h03;
            ppre_pkg::FMT_PAL4: return 8'h0F;
            default:  return 8'hFF;
        endcase
    endfunction

    // short channels are widened by repeating their top bits
    function automatic logic [31:0] rgba_of(logic [3:0] fmt, logic [31:0] c);
        case (fmt)
            ppre_pkg::FMT_PAL1, ppre_pkg::FMT_PAL2, ppre_pkg::FMT_PAL4, ppre_pkg::FMT_PAL8:
                return pal_shadow[c[7:0] & index_mask(fmt)];
            ppre_pkg::FMT_RGBA2321:
                return {{4{c[30:29]}}, c[4:2], c[4:2], c[4:3], {4{c[25:24]}}, {8{c[31]}}};
            ppre_pkg::FMT_RGB565:
                return {c[31:27], c[31:29], c[26:21], c[26:25], c[20:16], c[20:18], 8'h00};
            ppre_pkg::FMT_RGBA5551, ppre_pkg::FMT_RGBI5551:
                return {c[30:26], c[30:28], c[25:21], c[25:23], c[20:16], c[20:18],
                        {8{c[31]}}};
            ppre_pkg::FMT_RGB666:
                return {c[17:12], c[17:16], c[11:6], c[11:10], c[5:0], c[5:4], 8'h00};
            ppre_pkg::FMT_RGBA6661:
                return {c[17:12], c[17:16], c[11:6], c[11:10], c[5:0], c[5:4], {8{c[18]}}};
            ppre_pkg::FMT_RGBA6651:
                return {c[16:11], c[16:15], c[10:5], c[10:9], c[4:0], c[4:2], {8{c[17]}}};
            ppre_pkg::FMT_RGB888:
                return {c[23:0], 8'h00};
            ppre_pkg::FMT_RGBA8871:
                return {c[22:0], c[6], {8{c[23]}}};
            ppre_pkg::FMT_RGBA8881:
                return {c[23:0], {8{c[24]}}};
            ppre_pkg::FMT_RGBA8884:
                return {c[23:0], c[27:24], c[27:24]};
            default:
                return 32'h0;
        endcase
    endfunction

    task automatic send_item(logic cmd, logic [31:0] color, logic [7:0] idx, logic [31:0] val);
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {val, idx, color};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (cmd == ppre_pkg::CMD_WRITE)
        begin
            pal_shadow[idx]  = val;
            pal_written[idx] = 1'b1;
        end
        else
            rgba_due.push_back(rgba_of(fmt_now, color));
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(posedge clk);
        end
    endtask

    // palette writes give no result, so wait out the pipeline after the last rgba
    task automatic settle_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (rgba_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_pixel_format(logic [3:0] code);
        settle_idle();
        @(negedge clk);
        pixel_format_we    <= 1'b1;
        pixel_format_wdata <= code;
        @(posedge clk);
        fmt_now = code;
        @(negedge clk);
        pixel_format_we <= 1'b0;
    endtask

    // receiver: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        int stall_left;
        int hold_left;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (rx_idle_en)
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    m_axis_tready <= 1'b0;
                    stall_left--;
                end
                else
                    m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (rgba_due.size() == 0)
            begin
                $display("%0t: unexpected rgba transfer, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                rgba_want = rgba_due.pop_front();
                if (m_axis_tdata !== rgba_want)
                begin
                    $display("%0t: rgba mismatch, expected %h, actual %h",
                             $time, rgba_want, m_axis_tdata);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_reset_format();
        send_item(ppre_pkg::CMD_CONVERT, 32'hFFFF_FFFF, 8'h00, 32'h0);
        send_item(ppre_pkg::CMD_CONVERT, 32'h0000_0000, 8'h00, 32'h0);
    endtask

    task automatic test_palette_formats();
        send_item(ppre_pkg::CMD_WRITE, 32'h0, 8'h00, 32'h0000_0000);
        send_item(ppre_pkg::CMD_WRITE, 32'h0, 8'h01, 32'hFFFF_FFFF);
        send_item(ppre_pkg::CMD_WRITE, 32'h0, 8'h0F, 32'h1234_5678);
        send_item(ppre_pkg::CMD_WRITE, 32'h0, 8'hFF, 32'hA5C3_3C5A);
        set_pixel_format(ppre_pkg::FMT_PAL1);
        send_item(ppre_pkg::CMD_CONVERT, 32'hFFFF_FFFF, 8'h00, 32'h0);
        set_pixel_format(ppre_pkg::FMT_PAL2);
        send_item(ppre_pkg::CMD_CONVERT, 32'hFFFF_FFFC, 8'h00, 32'h0);
        set_pixel_format(ppre_pkg::FMT_PAL4);
        send_item(ppre_pkg::CMD_CONVERT, 32'h0000_000F, 8'h00, 32'h0);
        set_pixel_format(ppre_pkg::FMT_PAL8);
        send_item(ppre_pkg::CMD_CONVERT, 32'hFFFF_FFFF, 8'h00, 32'h0);
        // read right behind the write of the same entry
        send_item(ppre_pkg::CMD_WRITE, 32'h0, 8'h80, 32'h8421_1248);
        send_item(ppre_pkg::CMD_CONVERT, 32'h0000_0080, 8'h00, 32'h0);
    endtask

    task automatic test_direct_formats();
        for (int f = ppre_pkg::FMT_RGBA2321; f <= FMT_UNUSED; f++)
        begin
            set_pixel_format(4'(f));
            send_item(ppre_pkg::CMD_CONVERT, 32'hFFFF_FFFF, 8'h00, 32'h0);
        end
    endtask

    task automatic test_input_stall();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_pixel_format(ppre_pkg::FMT_RGBA5551);
        hold_requests++;
        repeat (40) send_item(ppre_pkg::CMD_CONVERT, $urandom, 8'($urandom), $urandom);
    endtask

    task automatic random_item(logic [3:0] fmt);
        logic [31:0] color;
        logic [7:0]  idx;
        if ($urandom_range(0, 4) == 0)
            send_item(ppre_pkg::CMD_WRITE, $urandom,
                      8'($urandom) & index_mask(fmt), $urandom);
        else
        begin
            color = $urandom;
            if (fmt <= ppre_pkg::FMT_PAL8)
            begin
                // never read an entry that was not written
                idx = color[7:0] & index_mask(fmt);
                if (!pal_written[idx])
                    send_item(ppre_pkg::CMD_WRITE, $urandom, idx, $urandom);
            end
            send_item(ppre_pkg::CMD_CONVERT, color, 8'($urandom), $urandom);
        end
    endtask

    task automatic test_random_phases();
        logic [3:0] fmt;
        for (int p = 0; p < 16; p++)
        begin
            fmt = 4'(p);
            set_pixel_format(fmt);
            tx_idle_en = (p % 3 != 0);
            rx_idle_en = (p % 3 != 1);
            repeat (PHASE_ITEMS) random_item(fmt);
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        pixel_format_we    = 1'b0;
        pixel_format_wdata = 4'd0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        s_axis_tuser       = ppre_pkg::CMD_CONVERT;
        fmt_now            = ppre_pkg::FMT_RGB565;
        tx_idle_en         = 1'b0;
        rx_idle_en         = 1'b0;
        mismatches         = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_format();
        test_palette_formats();
        test_direct_formats();
        test_input_stall();
        test_random_phases();

        settle_idle();
        if (mismatches == 0 && rgba_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
design/ppre_pkg.sv
design/ppre_palette_ram.sv
design/ppre_direct_expand.sv
design/packed_pixel_to_rgba_expander_core.sv
design/ppre_checker.sv
tb/tb_packed_pixel_to_rgba_expander_core.sv
